>>> hw/rtl/cache_address_mapper_top_defines.svh
// Assertion macros for the cache address mapper.
`ifndef CACHE_ADDRESS_MAPPER_TOP_DEFINES_SVH
`define CACHE_ADDRESS_MAPPER_TOP_DEFINES_SVH
// Assert that a condition implies another at the same edge.
`define CAM_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("cam check failed");
// Assert that a condition implies another at the next edge.
`define CAM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("cam check failed");
`endif

>>> hw/rtl/cam_pkg.sv
`timescale 1ns / 1ps
package cam_pkg;
	localparam int unsigned MAX_LINES_D = 65536;
	localparam int unsigned ADDR_BITS_D = 64;
	localparam int unsigned MAX_BANKS_D = 64;
	localparam logic [2:0] REG_LSB = 3'd0;
	localparam logic [2:0] REG_LINES = 3'd1;
	localparam logic [2:0] REG_WAYS = 3'd2;
	localparam logic [2:0] REG_BANKS = 3'd3;
	localparam logic [2:0] REG_BSEL = 3'd4;
	localparam logic CMD_SPLIT = 1'b0;
	localparam logic CMD_BUILD = 1'b1;

	// Derived configuration, worked out after reset and again after a register write.
	typedef struct packed {
		logic [3:0] lsb;
		logic [20:0] nsets;
		logic [8:0] nbanks;
		logic [6:0] bsel_w;
		logic np_sets;
		logic np_banks;
		logic plain;
		logic [6:0] bank_low;
		logic [6:0] tag_lo;
	} derived_t;

	function automatic logic [63:0] shl64(input logic [63:0] v, input logic [7:0] s);
		shl64 = (s >= 8'd64) ? 64'd0 : (v << s[5:0]);
	endfunction

	function automatic logic [63:0] shr64(input logic [63:0] v, input logic [7:0] s);
		shr64 = (s >= 8'd64) ? 64'd0 : (v >> s[5:0]);
	endfunction

	function automatic logic [63:0] lmask(input logic [7:0] n);
		lmask = (n >= 8'd64) ? '1 : ((64'd1 << n[5:0]) - 64'd1);
	endfunction
endpackage

>>> hw/rtl/cam_cfg.sv
`timescale 1ns / 1ps
// Configuration registers and derived values; the derivation is a registered
// multi-cycle result settled while the block is idle.
module cam_cfg #(
	parameter int unsigned MAX_LINES = cam_pkg::MAX_LINES_D,
	parameter int unsigned MAX_BANKS = cam_pkg::MAX_BANKS_D
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data,
	output cam_pkg::derived_t der
);
	localparam logic [20:0] MAXL = 21'(MAX_LINES);
	localparam logic [8:0] MAXB = 9'(MAX_BANKS);
	logic [3:0] lsb_q;
	logic [16:0] lines_q, ways_q;
	logic [6:0] banks_q;
	logic [5:0] bsel_q;
	logic [20:0] nlines_q, assoc_q;
	logic [4:0] lbits_q, abits_q;
	logic [8:0] nbanks_q;
	// Sequential divider for set count.
	logic [20:0] quo_q, rem_q;
	logic [4:0] dcnt_q;
	logic busy_q;
	cam_pkg::derived_t der_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsb_q <= 4'd6;
			lines_q <= 17'd512;
			ways_q <= 17'd4;
			banks_q <= 7'd1;
			bsel_q <= 6'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cam_pkg::REG_LSB: lsb_q <= cfg_data[3:0];
				cam_pkg::REG_LINES: lines_q <= cfg_data[16:0];
				cam_pkg::REG_WAYS: ways_q <= cfg_data[16:0];
				cam_pkg::REG_BANKS: banks_q <= cfg_data[6:0];
				cam_pkg::REG_BSEL: bsel_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	function automatic logic [4:0] flog2(input logic [20:0] v);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 0; i < 21; i++)
			if (v[i]) r = 5'(i);
		flog2 = r;
	endfunction

	// Stage A: clamp counts.
	logic [20:0] nl_c;
	logic [8:0] nb_c;
	always_comb begin
		nl_c = (lines_q == 17'd0) ? 21'd1 : 21'(lines_q);
		if (nl_c > MAXL) nl_c = MAXL;
		nb_c = (banks_q == 7'd0) ? 9'd1 : 9'(banks_q);
		if (nb_c > MAXB) nb_c = MAXB;
	end

	always_ff @(posedge clk) begin
		nlines_q <= nl_c;
		assoc_q <= (ways_q == 17'd0) ? nl_c : 21'(ways_q);
		nbanks_q <= nb_c;
		lbits_q <= flog2(nl_c);
		abits_q <= flog2((ways_q == 17'd0) ? nl_c : 21'(ways_q));
	end

	// Restart the divider whenever a write lands; run one quotient bit a cycle.
	logic [21:0] trial;
	assign trial = {rem_q, quo_q[20]} - {1'b0, assoc_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			dcnt_q <= 5'd0;
		end else if (cfg_valid) begin
			busy_q <= 1'b1;
			dcnt_q <= 5'd0;
		end else if (busy_q) begin
			dcnt_q <= dcnt_q + 5'd1;
			if (dcnt_q == 5'd23) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && dcnt_q < 5'd2) begin
			quo_q <= nlines_q;
			rem_q <= '0;
		end else if (busy_q && dcnt_q < 5'd23) begin
			if (!trial[21]) begin
				rem_q <= trial[20:0];
				quo_q <= {quo_q[19:0], 1'b1};
			end else begin
				rem_q <= {rem_q[19:0], quo_q[20]};
				quo_q <= {quo_q[19:0], 1'b0};
			end
		end
	end

	// Final derivation, latched once the divider has finished.
	logic [4:0] bb;
	logic [6:0] ib, ib2;
	logic pl, nps;
	always_comb begin
		bb = flog2(21'(nbanks_q));
		nps = nlines_q != (21'd1 << lbits_q);
		pl = (bsel_q == 6'd0) || (bsel_q == 6'(lsb_q));
		ib = (lbits_q > abits_q) ? 7'(lbits_q - abits_q) : 7'd0;
		ib2 = pl ? ib : ((ib > 7'(bb)) ? ib - 7'(bb) : 7'd0);
	end

	always_ff @(posedge clk) begin
		if (busy_q && dcnt_q == 5'd23) begin
			der_q.lsb <= lsb_q;
			der_q.nsets <= (quo_q == 21'd0) ? 21'd1 : quo_q;
			der_q.nbanks <= nbanks_q;
			der_q.bsel_w <= 7'(bb);
			der_q.np_sets <= nps;
			der_q.np_banks <= nbanks_q != (9'd1 << bb);
			der_q.plain <= pl;
			der_q.bank_low <= pl ? 7'(lsb_q) : 7'(bsel_q);
			der_q.tag_lo <= nps ? 7'(lsb_q) : ib2 + 7'(lsb_q);
		end
	end
	assign der = der_q;
endmodule

>>> hw/rtl/cam_mod.sv
`timescale 1ns / 1ps
// Pipelined remainder of a line number by a small divisor: one restoring
// step per dividend bit, W / STAGES bits per stage rounded up (eight by default).
module cam_mod #(
	parameter int unsigned W = 64,
	parameter int unsigned DW = 21,
	parameter int unsigned STAGES = 8
) (
	input logic clk,
	input logic adv,
	input logic [W-1:0] num,
	input logic [DW-1:0] den,
	output logic [DW-1:0] rem
);
	localparam int unsigned BPS = (W + STAGES - 1) / STAGES;
	localparam int unsigned PW = BPS * STAGES;
	logic [PW-1:0] n_s [STAGES+1];
	logic [DW-1:0] r_s [STAGES+1];
	logic [DW-1:0] d_s [STAGES+1];

	assign n_s[0] = PW'(num);
	assign r_s[0] = '0;
	assign d_s[0] = den;

	for (genvar g = 0; g < STAGES; g++) begin : g_st
		logic [PW-1:0] n_c;
		logic [DW-1:0] r_c;
		always_comb begin
			logic [DW:0] t;
			n_c = n_s[g];
			r_c = r_s[g];
			for (int b = 0; b < BPS; b++) begin
				t = {r_c, n_c[PW-1]};
				n_c = n_c << 1;
				if (t >= {1'b0, d_s[g]}) t = t - {1'b0, d_s[g]};
				r_c = t[DW-1:0];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[g+1] <= n_c;
				r_s[g+1] <= r_c;
				d_s[g+1] <= d_s[g];
			end
		end
	end
	assign rem = r_s[STAGES];
endmodule

>>> hw/rtl/cache_address_mapper_top.sv
`timescale 1ns / 1ps
// Cache address mapper. Splits an address into tag, set index, line offset,
// bank and line address (command 0), or rebuilds an address from tag, index
// and offset (command 1). One beat is accepted every cycle while the output
// is not stalled; the input register takes the beat, eight remainder stages
// follow for non-power-of-two set and bank counts, and the field logic feeds
// the output register. Backpressure stalls the whole pipeline. After reset or
// a configuration write the derived values are worked out again by the
// bit-serial set-count divider; write configuration only idle.
module cache_address_mapper_top #(
	parameter int unsigned MAX_LINES = cam_pkg::MAX_LINES_D,
	parameter int unsigned ADDR_BITS = cam_pkg::ADDR_BITS_D,
	parameter int unsigned MAX_BANKS = cam_pkg::MAX_BANKS_D
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic command,
	input logic [63:0] address,
	input logic [63:0] in_tag,
	input logic [15:0] in_index,
	input logic [11:0] in_offset,
	output logic out_valid,
	input logic out_ready,
	output logic [63:0] out_tag,
	output logic [15:0] out_index,
	output logic [11:0] out_offset,
	output logic [5:0] out_bank,
	output logic [63:0] line_address,
	output logic [63:0] built_address
);
	localparam int unsigned NST = 8;
	localparam int unsigned DEPTH = NST;
	localparam logic [63:0] AMASK = cam_pkg::lmask(8'(ADDR_BITS));

	cam_pkg::derived_t der;
	logic adv;

	cam_cfg #(.MAX_LINES(MAX_LINES), .MAX_BANKS(MAX_BANKS)) u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .der(der)
	);

	// Advance the whole pipe when the output slot is free or being drained.
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: register the beat, masked address and line number.
	logic v_s1, cmd_s1;
	logic [63:0] a_s1, tag_s1;
	logic [15:0] idx_s1;
	logic [11:0] off_s1;
	logic [63:0] ln_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= command;
			a_s1 <= address & AMASK;
			tag_s1 <= in_tag;
			idx_s1 <= in_index;
			off_s1 <= in_offset;
			ln_s1 <= (address & AMASK) >> der.lsb;
		end
	end

	// Remainder pipes for set and bank index.
	logic [20:0] set_rem, bank_rem;
	cam_mod #(.W(64), .DW(21), .STAGES(NST)) u_mset (
		.clk(clk), .adv(adv), .num(ln_s1), .den(der.nsets), .rem(set_rem)
	);
	cam_mod #(.W(64), .DW(21), .STAGES(NST)) u_mbank (
		.clk(clk), .adv(adv), .num(ln_s1), .den(21'(der.nbanks)), .rem(bank_rem)
	);

	// Delay line carries the beat alongside the remainder stages.
	logic v_d [DEPTH];
	logic c_d [DEPTH];
	logic [63:0] a_d [DEPTH];
	logic [63:0] t_d [DEPTH];
	logic [15:0] i_d [DEPTH];
	logic [11:0] o_d [DEPTH];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) v_d[k] <= 1'b0;
		end else if (adv) begin
			v_d[0] <= v_s1;
			for (int k = 1; k < DEPTH; k++) v_d[k] <= v_d[k-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			c_d[0] <= cmd_s1;
			a_d[0] <= a_s1;
			t_d[0] <= tag_s1;
			i_d[0] <= idx_s1;
			o_d[0] <= off_s1;
			for (int k = 1; k < DEPTH; k++) begin
				c_d[k] <= c_d[k-1];
				a_d[k] <= a_d[k-1];
				t_d[k] <= t_d[k-1];
				i_d[k] <= i_d[k-1];
				o_d[k] <= o_d[k-1];
			end
		end
	end
	// Align the remainder taps: both finish at delay slot NST-1.
	logic v_x, c_x;
	logic [63:0] a_x, t_x;
	logic [15:0] i_x;
	logic [11:0] o_x;
	assign v_x = v_d[NST-1];
	assign c_x = c_d[NST-1];
	assign a_x = a_d[NST-1];
	assign t_x = t_d[NST-1];
	assign i_x = i_d[NST-1];
	assign o_x = o_d[NST-1];

	// Stage 2: field extraction and rebuild.
	logic [63:0] tg_c, ix_c, bk_c, work, built, bt, real_i, bkb;
	logic [7:0] lsb8, bl8, bb8, ts8;
	always_comb begin
		lsb8 = 8'(der.lsb);
		bl8 = 8'(der.bank_low);
		bb8 = 8'(der.bsel_w);
		ts8 = 8'(der.tag_lo);
		bk_c = der.np_banks ? 64'(bank_rem)
			: (cam_pkg::shr64(a_x, bl8) & cam_pkg::lmask(bb8));
		work = der.plain ? a_x : ((a_x & cam_pkg::lmask(bl8))
			| cam_pkg::shl64(cam_pkg::shr64(a_x, bl8 + bb8), bl8));
		tg_c = cam_pkg::shr64(work, ts8);
		if (der.np_sets) ix_c = 64'(set_rem);
		else if (der.plain)
			ix_c = cam_pkg::shr64(a_x, lsb8) & cam_pkg::lmask(ts8 - lsb8);
		else ix_c = cam_pkg::shl64(cam_pkg::shr64(work, lsb8)
			& cam_pkg::lmask(ts8 - lsb8), bb8) | bk_c;
		bkb = 64'(i_x) & cam_pkg::lmask(bb8);
		real_i = cam_pkg::shr64(64'(i_x), bb8);
		if (der.np_sets) bt = cam_pkg::shl64(t_x, ts8) | 64'(o_x);
		else if (der.plain) bt = cam_pkg::shl64(t_x, ts8)
			| cam_pkg::shl64(64'(i_x), lsb8) | 64'(o_x);
		else bt = cam_pkg::shl64(t_x, ts8) | cam_pkg::shl64(real_i, lsb8) | 64'(o_x);
		built = (der.np_sets || der.plain) ? bt : ((bt & cam_pkg::lmask(bl8))
			| cam_pkg::shl64(bkb, bl8) | cam_pkg::shl64(cam_pkg::shr64(bt, bl8), bl8 + bb8));
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_x;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			if (c_x == cam_pkg::CMD_SPLIT) begin
				out_tag <= tg_c;
				out_index <= ix_c[15:0];
				out_offset <= 12'(a_x & cam_pkg::lmask(lsb8));
				out_bank <= bk_c[5:0];
				line_address <= a_x & ~cam_pkg::lmask(lsb8) & AMASK;
				built_address <= '0;
			end else begin
				out_tag <= '0;
				out_index <= '0;
				out_offset <= '0;
				out_bank <= '0;
				line_address <= '0;
				built_address <= built & AMASK;
			end
		end
	end
endmodule

>>> hw/rtl/cam_checker.sv
`timescale 1ns / 1ps
`include "cache_address_mapper_top_defines.svh"
module cam_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [63:0] built_address,
	input logic [63:0] line_address
);
	// Hold a stalled result.
	`CAM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// Take input only when the output can move.
	`CAM_ASSERT_IMP(a_rdy, clk, arst_n, out_valid && !out_ready, !in_ready)
	// A result never carries both a split and a build.
	`CAM_ASSERT_IMP(a_excl, clk, arst_n, out_valid && built_address != 64'd0,
		line_address == 64'd0)
endmodule

bind cache_address_mapper_top cam_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .built_address(built_address), .line_address(line_address)
);
